// ===== rtl/led_border_effect_engine_assert.svh =====
`ifndef LED_BORDER_EFFECT_ENGINE_ASSERT_SVH
`define LED_BORDER_EFFECT_ENGINE_ASSERT_SVH

// same-cycle implication, checked on every edge out of reset
`define LBE_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define LBE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/lbe_pkg.sv =====
package lbe_pkg;

  localparam int LED_COUNT     = 60;
  localparam int SEGMENT_COUNT = 4;

  localparam int IDX_W = 6;
  localparam int REM_W = 6;
  localparam int BAR_W = 13;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_FILL = 3'd2;
  localparam logic [2:0] OP_SEG = 3'd3;
  localparam logic [2:0] OP_BAR = 3'd4;
  localparam logic [2:0] OP_SET = 3'd5;

  localparam logic [2:0] FX_NONE = 3'd0;
  localparam logic [2:0] FX_RAINBOW = 3'd1;
  localparam logic [2:0] FX_FADE = 3'd2;
  localparam logic [2:0] FX_UP = 3'd3;
  localparam logic [2:0] FX_DOWN = 3'd4;
  localparam logic [2:0] FX_FLASH = 3'd5;
  localparam logic [2:0] FX_LOADER = 3'd6;

  localparam logic [1:0] CFG_LOADER_W = 2'd0;
  localparam logic [1:0] CFG_SEG_START = 2'd1;
  localparam logic [1:0] CFG_SEG_END = 2'd2;

  localparam logic [7:0] FADE_STEP = 8'd5;
  localparam logic [7:0] FADE_TOP = 8'd250;
  localparam logic [7:0] LEVEL_MAX = 8'd255;
  localparam logic [7:0] PCT_MAX = 8'd100;
  localparam logic [7:0] WHEEL_A = 8'd85;
  localparam logic [7:0] WHEEL_B = 8'd170;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
  localparam logic [6:0] LED_COUNT_7 = 7'(LED_COUNT);
  localparam logic [7:0] LED_COUNT_8 = 8'(LED_COUNT);
  localparam logic [BAR_W-1:0] LED_COUNT_B = BAR_W'(LED_COUNT);
  localparam logic [7:0] SEG_COUNT_8 = 8'(SEGMENT_COUNT);

  // rainbow hue advances by 255/LED_COUNT per pixel, remainder carried
  localparam logic [7:0] HUE_Q = 8'(255 / LED_COUNT);
  localparam logic [REM_W:0] HUE_R = (REM_W + 1)'(255 % LED_COUNT);

  typedef enum logic [1:0] {
    PM_CONST,
    PM_BAR,
    PM_WHEEL,
    PM_LOADER
  } pix_mode_t;

  typedef struct packed {
    logic             load;
    logic             step;
    pix_mode_t        mode;
    logic [IDX_W-1:0] idx;
  } pix_ctrl_t;

endpackage

// ===== rtl/lbe_scaler.sv =====
module lbe_scaler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        run,
  input  logic [23:0] color,
  input  logic [7:0]  level,
  output logic        done,
  output logic [23:0] result
);
  import lbe_pkg::*;

  logic [1:0]  cnt_r;
  logic [15:0] prod_r;
  logic [15:0] res_r;
  logic [7:0]  chan;
  logic [16:0] div_sum;
  logic [7:0]  quot;

  // one 8x8 multiplier shared by the three channels
  always_comb begin
    case (cnt_r)
      2'd0: chan = color[7:0];
      2'd1: chan = color[15:8];
      default: chan = color[23:16];
    endcase
  end

  // floor(x / 255) for x <= 255*255, any 8x8 product
  assign div_sum = {1'b0, prod_r} + {9'd0, prod_r[15:8]} + 17'd1;
  assign quot    = div_sum[15:8];

  assign done   = run && (cnt_r == 2'd3);
  assign result = {quot, res_r[15:8], res_r[7:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (!run) begin
      cnt_r <= 2'd0;
    end else if (cnt_r != 2'd3) begin
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (run && cnt_r != 2'd3) begin
      prod_r <= 16'(chan) * 16'(level);
    end
    if (run && cnt_r == 2'd1) begin
      res_r[7:0] <= quot;
    end
    if (run && cnt_r == 2'd2) begin
      res_r[15:8] <= quot;
    end
  end

endmodule

// ===== rtl/lbe_pixel_gen.sv =====
module lbe_pixel_gen (
  input  logic                        clk,
  input  lbe_pkg::pix_ctrl_t          ctrl,
  input  logic [23:0]                 base_color,
  input  logic [lbe_pkg::BAR_W-1:0]   bar_lim,
  input  logic [7:0]                  hue,
  input  logic [lbe_pkg::IDX_W-1:0]   marker,
  input  logic [7:0]                  loader_width,
  output logic [23:0]                 pixel_color
);
  import lbe_pkg::*;

  logic [7:0]       hue_pos_r;
  logic [REM_W-1:0] hue_rem_r;
  logic [IDX_W-1:0] dist_r;

  logic [REM_W:0]   rem_sum;
  logic [6:0]       dist_start;
  logic [6:0]       idx_p1;
  logic [BAR_W-1:0] bar_lhs;
  logic [23:0]      wheel_color;

  function automatic logic [23:0] color_wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] t;
    logic [7:0] t3;
    begin
      p = ~pos;
      if (p < WHEEL_A) begin
        t3 = 8'(p * 8'd3);
        color_wheel = {LEVEL_MAX - t3, 8'd0, t3};
      end else if (p < WHEEL_B) begin
        t  = p - WHEEL_A;
        t3 = 8'(t * 8'd3);
        color_wheel = {8'd0, t3, LEVEL_MAX - t3};
      end else begin
        t  = p - WHEEL_B;
        t3 = 8'(t * 8'd3);
        color_wheel = {t3, LEVEL_MAX - t3, 8'd0};
      end
    end
  endfunction

  assign rem_sum    = {1'b0, hue_rem_r} + HUE_R;
  // distance of pixel 0 from the marker, (LED_COUNT - marker) mod LED_COUNT
  assign dist_start = (marker == '0) ? 7'd0 : (LED_COUNT_7 - {1'b0, marker});
  assign idx_p1     = {1'b0, ctrl.idx} + 7'd1;
  assign bar_lhs    = BAR_W'(idx_p1) * BAR_W'(PCT_MAX);
  assign wheel_color = color_wheel(hue_pos_r);

  always_comb begin
    case (ctrl.mode)
      PM_CONST:  pixel_color = base_color;
      PM_BAR:    pixel_color = (bar_lhs <= bar_lim) ? base_color : 24'd0;
      PM_WHEEL:  pixel_color = wheel_color;
      PM_LOADER: pixel_color = ({2'd0, dist_r} < loader_width) ? ~base_color : base_color;
      default:   pixel_color = base_color;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      hue_pos_r <= hue;
      hue_rem_r <= '0;
      dist_r    <= dist_start[IDX_W-1:0];
    end else if (ctrl.step) begin
      if (rem_sum >= LED_COUNT_7) begin
        hue_rem_r <= REM_W'(rem_sum - LED_COUNT_7);
        hue_pos_r <= hue_pos_r + HUE_Q + 8'd1;
      end else begin
        hue_rem_r <= rem_sum[REM_W-1:0];
        hue_pos_r <= hue_pos_r + HUE_Q;
      end
      dist_r <= (dist_r == LAST_IDX) ? '0 : dist_r + 1'b1;
    end
  end

endmodule

// ===== rtl/led_border_effect_engine.sv =====
// After an item is taken the engine enters ST_EMIT and registers each pixel into
// the output register; fade, fade up and fade down pass through ST_SCALE first,
// which runs the shared 8x8 scaler over the three channels. One pixel per cycle
// goes out while out_ready is high; the next item is taken once the last pixel
// sits in the output register. Items that emit nothing leave the engine idle. Reset
// (rst_n low, synchronous) clears the effect state and loads the config defaults.
module led_border_effect_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_operation,
  input  logic [31:0]               in_now_ms,
  input  logic [23:0]               in_color,
  input  logic [7:0]                in_segment_index,
  input  logic [7:0]                in_percent,
  input  logic [2:0]                in_effect_kind,
  input  logic [31:0]               in_interval_ms,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lbe_pkg::IDX_W-1:0] out_pixel_index,
  output logic [23:0]               out_pixel_color,
  output logic                      out_last
);
  import lbe_pkg::*;

  `include "led_border_effect_engine_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCALE = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  loader_w_r;
  logic [31:0] seg_start_r;
  logic [31:0] seg_end_r;

  logic [2:0]  active_r, active_nxt;
  logic [31:0] interval_r, interval_nxt;
  logic [23:0] rgb_r, rgb_nxt;
  logic [7:0]  level_r, level_nxt;
  logic        rising_r, rising_nxt;
  logic [IDX_W-1:0] marker_r, marker_nxt;
  logic [7:0]  hue_r, hue_nxt;
  logic [31:0] last_ms_r, last_ms_nxt;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] end_r, end_nxt;
  pix_mode_t        mode_r, mode_nxt;
  logic [23:0]      col_r, col_nxt;
  logic [BAR_W-1:0] lim_r, lim_nxt;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [23:0]      out_col_r;
  logic             out_last_r;

  logic        accept;
  logic        emit_go;
  logic        tick_due;
  logic [31:0] elapsed;
  logic [7:0]  seg_s;
  logic [7:0]  seg_e;
  logic [7:0]  seg_e_clip;
  logic [7:0]  pct_clamp;
  logic [7:0]  lvl_up;
  logic [7:0]  lvl_dn;
  logic [7:0]  lvl_base;
  logic        scl_done;
  logic [23:0] scl_result;
  logic [23:0] pix_color;
  pix_ctrl_t   pix_ctrl;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  assign elapsed  = in_now_ms - last_ms_r;
  assign tick_due = (active_r != FX_NONE) && (elapsed >= interval_r);

  assign seg_s      = seg_start_r[{in_segment_index[1:0], 3'b000} +: 8];
  assign seg_e      = seg_end_r[{in_segment_index[1:0], 3'b000} +: 8];
  assign seg_e_clip = (seg_e >= LED_COUNT_8) ? LED_COUNT_8 - 8'd1 : seg_e;
  assign pct_clamp  = (in_percent > PCT_MAX) ? PCT_MAX : in_percent;

  assign lvl_up   = level_r + FADE_STEP;
  assign lvl_dn   = level_r - FADE_STEP;
  assign lvl_base = (level_r == 8'd0) ? LEVEL_MAX : level_r;

  assign pix_ctrl.load = accept;
  assign pix_ctrl.step = emit_go;
  assign pix_ctrl.mode = mode_r;
  assign pix_ctrl.idx  = idx_r;

  lbe_scaler u_scaler (
    .clk    (clk),
    .rst_n  (rst_n),
    .run    (state_r == ST_SCALE),
    .color  (col_r),
    .level  (level_r),
    .done   (scl_done),
    .result (scl_result)
  );

  lbe_pixel_gen u_pixel_gen (
    .clk          (clk),
    .ctrl         (pix_ctrl),
    .base_color   (col_r),
    .bar_lim      (lim_r),
    .hue          (hue_r),
    .marker       (marker_r),
    .loader_width (loader_w_r),
    .pixel_color  (pix_color)
  );

  always_comb begin
    state_nxt    = state_r;
    active_nxt   = active_r;
    interval_nxt = interval_r;
    rgb_nxt      = rgb_r;
    level_nxt    = level_r;
    rising_nxt   = rising_r;
    marker_nxt   = marker_r;
    hue_nxt      = hue_r;
    last_ms_nxt  = last_ms_r;
    idx_nxt      = idx_r;
    end_nxt      = end_r;
    mode_nxt     = mode_r;
    col_nxt      = col_r;
    lim_nxt      = lim_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt  = '0;
          end_nxt  = LAST_IDX;
          mode_nxt = PM_CONST;
          case (in_operation)
            OP_TICK: begin
              if (tick_due) begin
                last_ms_nxt = in_now_ms;
                col_nxt     = rgb_r;
                case (active_r)
                  FX_RAINBOW: begin
                    mode_nxt  = PM_WHEEL;
                    hue_nxt   = hue_r + 8'd1;
                    state_nxt = ST_EMIT;
                  end
                  FX_FADE: begin
                    if (rising_r) begin
                      if (lvl_up >= FADE_TOP) begin
                        level_nxt  = LEVEL_MAX;
                        rising_nxt = 1'b0;
                      end else begin
                        level_nxt = lvl_up;
                      end
                    end else begin
                      if (lvl_dn <= FADE_STEP) begin
                        level_nxt  = 8'd0;
                        rising_nxt = 1'b1;
                      end else begin
                        level_nxt = lvl_dn;
                      end
                    end
                    state_nxt = ST_SCALE;
                  end
                  FX_UP: begin
                    level_nxt = (lvl_up == LEVEL_MAX) ? 8'd0 : lvl_up;
                    state_nxt = ST_SCALE;
                  end
                  FX_DOWN: begin
                    level_nxt = lvl_base - FADE_STEP;
                    state_nxt = ST_SCALE;
                  end
                  FX_FLASH: begin
                    rising_nxt = !rising_r;
                    col_nxt    = rising_r ? 24'd0 : rgb_r;
                    state_nxt  = ST_EMIT;
                  end
                  FX_LOADER: begin
                    mode_nxt   = PM_LOADER;
                    marker_nxt = (marker_r == LAST_IDX) ? '0 : marker_r + 1'b1;
                    state_nxt  = ST_EMIT;
                  end
                  default: state_nxt = ST_IDLE;
                endcase
              end
            end
            OP_CLEAR: begin
              active_nxt = FX_NONE;
              col_nxt    = 24'd0;
              state_nxt  = ST_EMIT;
            end
            OP_FILL: begin
              active_nxt = FX_NONE;
              col_nxt    = in_color;
              state_nxt  = ST_EMIT;
            end
            OP_SEG: begin
              if (in_segment_index < SEG_COUNT_8) begin
                active_nxt = FX_NONE;
                // nothing to draw when the start lies past the end or the strip
                if (seg_s <= seg_e && seg_s < LED_COUNT_8) begin
                  idx_nxt   = seg_s[IDX_W-1:0];
                  end_nxt   = seg_e_clip[IDX_W-1:0];
                  col_nxt   = in_color;
                  state_nxt = ST_EMIT;
                end
              end
            end
            OP_BAR: begin
              active_nxt = FX_NONE;
              lim_nxt    = LED_COUNT_B * BAR_W'(pct_clamp);
              col_nxt    = in_color;
              mode_nxt   = PM_BAR;
              state_nxt  = ST_EMIT;
            end
            OP_SET: begin
              active_nxt   = (in_effect_kind <= FX_LOADER) ? in_effect_kind : FX_NONE;
              interval_nxt = in_interval_ms;
              rgb_nxt      = in_color;
              level_nxt    = 8'd0;
              rising_nxt   = 1'b1;
              marker_nxt   = '0;
              last_ms_nxt  = in_now_ms;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCALE: begin
        if (scl_done) begin
          col_nxt   = scl_result;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          if (idx_r == end_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loader_w_r  <= 8'd1;
      seg_start_r <= 32'd0;
      seg_end_r   <= 32'd0;
      active_r    <= FX_NONE;
      interval_r  <= 32'd0;
      rgb_r       <= 24'd0;
      level_r     <= 8'd0;
      rising_r    <= 1'b1;
      marker_r    <= '0;
      hue_r       <= 8'd0;
      last_ms_r   <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      interval_r <= interval_nxt;
      rgb_r      <= rgb_nxt;
      level_r    <= level_nxt;
      rising_r   <= rising_nxt;
      marker_r   <= marker_nxt;
      hue_r      <= hue_nxt;
      last_ms_r  <= last_ms_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOADER_W:  loader_w_r  <= cfg_wdata[7:0];
          CFG_SEG_START: seg_start_r <= cfg_wdata;
          CFG_SEG_END:   seg_end_r   <= cfg_wdata;
          default:       loader_w_r  <= loader_w_r;
        endcase
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    end_r  <= end_nxt;
    mode_r <= mode_nxt;
    col_r  <= col_nxt;
    lim_r  <= lim_nxt;
    if (emit_go) begin
      out_idx_r  <= idx_r;
      out_col_r  <= pix_color;
      out_last_r <= (idx_r == end_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_idx_r;
  assign out_pixel_color = out_col_r;
  assign out_last        = out_last_r;

  `LBE_ASSERT_NOW(a_emit_in_range, state_r == ST_EMIT, idx_r <= end_r, "pixel index past end")
  `LBE_ASSERT_NOW(a_scale_done_state, scl_done, state_r == ST_SCALE, "scaler done outside scale")
  `LBE_ASSERT_NEXT(a_idle_tick, accept && in_operation == OP_TICK && !tick_due, state_r == ST_IDLE, "idle tick left idle")

endmodule
